[sv/clebuf_pkg.sv]
// Shared types and character codes for the console line editing buffer.
package clebuf_pkg;

  // Character codes that steer the line editor.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_CTRL_H = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // Largest erase count that the result field can report.
  localparam logic [7:0] ERASE_MAX = 8'hFF;

  // Item codes on the cmd field.
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_EVAL,
    ST_KILL_EVAL,
    ST_FINISH
  } state_t;

  // Which pointer addresses the line store on a read.
  typedef enum logic [1:0] {
    ADDR_READ,
    ADDR_EDIT_DEC,
    ADDR_EDIT_DEC2
  } addr_sel_t;

  typedef struct packed {
    logic      capture;
    logic      exec_byte;
    logic      mem_rd;
    addr_sel_t addr_sel;
    logic      set_empty;
    logic      read_done;
    logic      kill_step;
    logic      load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_kill;
    logic ptr_empty;
    logic line_empty;
    logic rdata_lf;
    logic ep_dec_is_cp;
    logic out_free;
  } dp_status_t;

endpackage

[sv/clebuf_ctrl.sv]
// Controller state machine of the console line editing buffer.
module clebuf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  clebuf_pkg::dp_status_t status,
  output clebuf_pkg::ctrl_cmd_t  cmd_o
);

  clebuf_pkg::state_t state;
  clebuf_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clebuf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      clebuf_pkg::ST_IDLE: begin
        if (in_valid) state_next = clebuf_pkg::ST_DECODE;
      end
      clebuf_pkg::ST_DECODE: begin
        priority if (status.is_read) begin
          state_next = status.ptr_empty ? clebuf_pkg::ST_FINISH : clebuf_pkg::ST_READ_EVAL;
        end else if (status.is_kill) begin
          state_next = status.line_empty ? clebuf_pkg::ST_FINISH : clebuf_pkg::ST_KILL_EVAL;
        end else begin
          state_next = clebuf_pkg::ST_FINISH;
        end
      end
      clebuf_pkg::ST_READ_EVAL: begin
        state_next = clebuf_pkg::ST_FINISH;
      end
      clebuf_pkg::ST_KILL_EVAL: begin
        if (status.rdata_lf || status.ep_dec_is_cp) state_next = clebuf_pkg::ST_FINISH;
      end
      clebuf_pkg::ST_FINISH: begin
        if (status.out_free) state_next = clebuf_pkg::ST_IDLE;
      end
      default: state_next = clebuf_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = clebuf_pkg::ADDR_READ;
    in_ready       = 1'b0;
    unique case (state)
      clebuf_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.capture = in_valid;
      end
      clebuf_pkg::ST_DECODE: begin
        priority if (status.is_read) begin
          cmd_o.set_empty = status.ptr_empty;
          cmd_o.mem_rd    = !status.ptr_empty;
          cmd_o.addr_sel  = clebuf_pkg::ADDR_READ;
        end else if (status.is_kill) begin
          cmd_o.mem_rd   = !status.line_empty;
          cmd_o.addr_sel = clebuf_pkg::ADDR_EDIT_DEC;
        end else begin
          cmd_o.exec_byte = 1'b1;
        end
      end
      clebuf_pkg::ST_READ_EVAL: begin
        cmd_o.read_done = 1'b1;
      end
      clebuf_pkg::ST_KILL_EVAL: begin
        // Erase one byte per cycle and fetch the one before it.
        if (!status.rdata_lf) begin
          cmd_o.kill_step = 1'b1;
          cmd_o.mem_rd    = !status.ep_dec_is_cp;
          cmd_o.addr_sel  = clebuf_pkg::ADDR_EDIT_DEC2;
        end
      end
      clebuf_pkg::ST_FINISH: begin
        cmd_o.load_out = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[sv/clebuf_datapath.sv]
// Datapath of the console line editing buffer: pointers, line store and result registers.
module clebuf_datapath #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  clebuf_pkg::ctrl_cmd_t  cmd_i,
  output clebuf_pkg::dp_status_t status,
  input  logic                  cmd,
  input  logic [7:0]            rx_char,
  input  logic                  read_first,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  echo_valid,
  output logic [7:0]            echo_char,
  output logic [7:0]            erase_count,
  output logic                  dump_request,
  output logic                  line_ready,
  output logic                  read_valid,
  output logic [7:0]            read_char,
  output logic                  read_eof,
  output logic                  read_empty,
  output logic                  read_line_end
);

  localparam int PW = $clog2(2 * BUFFER_DEPTH);
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [PW-1:0] DEPTH_P    = PW'(BUFFER_DEPTH);
  localparam logic [PW-1:0] DEPTH_M1_P = PW'(BUFFER_DEPTH - 1);
  localparam logic [PW-1:0] LAST_P     = PW'(2 * BUFFER_DEPTH - 1);
  localparam logic [PW:0]   TWO_D_X    = (PW + 1)'(2 * BUFFER_DEPTH);

  // Pointer arithmetic, modulo twice the ring depth.
  function automatic logic [PW-1:0] p_inc(input logic [PW-1:0] p);
    return (p == LAST_P) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] p_dec(input logic [PW-1:0] p);
    return (p == '0) ? LAST_P : p - PW'(1);
  endfunction

  function automatic logic [AW-1:0] p_slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] p_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[PW]) d = d + TWO_D_X;
    return d[PW-1:0];
  endfunction

  logic [7:0] line_store [BUFFER_DEPTH];
  logic [7:0] rdata;

  logic [PW-1:0] read_pointer, read_pointer_next;
  logic [PW-1:0] commit_pointer, commit_pointer_next;
  logic [PW-1:0] edit_pointer, edit_pointer_next;

  // Captured item.
  logic       it_cmd;
  logic [7:0] it_char;
  logic       it_first;

  // Results gathered while the item is worked on.
  logic       res_echo_valid, res_echo_valid_next;
  logic [7:0] res_echo_char, res_echo_char_next;
  logic [7:0] res_erase, res_erase_next;
  logic       res_dump, res_dump_next;
  logic       res_line_ready, res_line_ready_next;
  logic       res_read_valid, res_read_valid_next;
  logic [7:0] res_read_char, res_read_char_next;
  logic       res_eof, res_eof_next;
  logic       res_empty, res_empty_next;
  logic       res_line_end, res_line_end_next;

  logic          wr_en;
  logic [7:0]    wr_char;
  logic [AW-1:0] raddr;
  logic [PW-1:0] ep_dec;
  logic [PW-1:0] fill;
  logic [7:0]    mapped;

  assign ep_dec = p_dec(edit_pointer);
  assign fill   = p_dist(edit_pointer, read_pointer);
  assign mapped = (it_char == clebuf_pkg::CH_CR) ? clebuf_pkg::CH_LF : it_char;

  // Status to the controller.
  always_comb begin
    status.is_read      = (it_cmd == clebuf_pkg::CMD_READ);
    status.is_kill      = (it_char == clebuf_pkg::CH_CTRL_U);
    status.ptr_empty    = (read_pointer == commit_pointer);
    status.line_empty   = (edit_pointer == commit_pointer);
    status.rdata_lf     = (rdata == clebuf_pkg::CH_LF);
    status.ep_dec_is_cp = (ep_dec == commit_pointer);
    status.out_free     = !out_valid || out_ready;
  end

  // Line store read address.
  always_comb begin
    unique case (cmd_i.addr_sel)
      clebuf_pkg::ADDR_READ:      raddr = p_slot(read_pointer);
      clebuf_pkg::ADDR_EDIT_DEC:  raddr = p_slot(ep_dec);
      clebuf_pkg::ADDR_EDIT_DEC2: raddr = p_slot(p_dec(ep_dec));
      default:                    raddr = p_slot(read_pointer);
    endcase
  end

  // Editing and reading decisions.
  always_comb begin
    read_pointer_next   = read_pointer;
    commit_pointer_next = commit_pointer;
    edit_pointer_next   = edit_pointer;
    res_echo_valid_next = res_echo_valid;
    res_echo_char_next  = res_echo_char;
    res_erase_next      = res_erase;
    res_dump_next       = res_dump;
    res_line_ready_next = res_line_ready;
    res_read_valid_next = res_read_valid;
    res_read_char_next  = res_read_char;
    res_eof_next        = res_eof;
    res_empty_next      = res_empty;
    res_line_end_next   = res_line_end;
    wr_en               = 1'b0;
    wr_char             = mapped;

    if (cmd_i.capture) begin
      res_echo_valid_next = 1'b0;
      res_echo_char_next  = '0;
      res_erase_next      = '0;
      res_dump_next       = 1'b0;
      res_line_ready_next = 1'b0;
      res_read_valid_next = 1'b0;
      res_read_char_next  = '0;
      res_eof_next        = 1'b0;
      res_empty_next      = 1'b0;
      res_line_end_next   = 1'b0;
    end

    // A received byte other than kill-line is done in one step.
    if (cmd_i.exec_byte) begin
      priority if (it_char == clebuf_pkg::CH_CTRL_P) begin
        res_dump_next = 1'b1;
      end else if (it_char == clebuf_pkg::CH_CTRL_H || it_char == clebuf_pkg::CH_DEL) begin
        if (edit_pointer != commit_pointer) begin
          edit_pointer_next = ep_dec;
          res_erase_next    = 8'd1;
        end
      end else if (it_char != clebuf_pkg::CH_NUL && fill < DEPTH_P) begin
        wr_en               = 1'b1;
        edit_pointer_next   = p_inc(edit_pointer);
        res_echo_valid_next = 1'b1;
        res_echo_char_next  = mapped;
        if (mapped == clebuf_pkg::CH_LF || mapped == clebuf_pkg::CH_CTRL_D ||
            fill == DEPTH_M1_P) begin
          commit_pointer_next = p_inc(edit_pointer);
          res_line_ready_next = 1'b1;
        end
      end else begin
        res_erase_next = '0;
      end
    end

    // Kill-line erases one byte per step.
    if (cmd_i.kill_step) begin
      edit_pointer_next = ep_dec;
      if (res_erase != clebuf_pkg::ERASE_MAX) res_erase_next = res_erase + 8'd1;
    end

    if (cmd_i.set_empty) res_empty_next = 1'b1;

    // A Ctrl-D ends the read call and is consumed only at its start.
    if (cmd_i.read_done) begin
      if (rdata == clebuf_pkg::CH_CTRL_D) begin
        if (it_first) read_pointer_next = p_inc(read_pointer);
        res_eof_next = 1'b1;
      end else begin
        read_pointer_next   = p_inc(read_pointer);
        res_read_valid_next = 1'b1;
        res_read_char_next  = rdata;
        res_line_end_next   = (rdata == clebuf_pkg::CH_LF);
      end
    end
  end

  // Line store.
  always_ff @(posedge clk) begin
    if (wr_en) line_store[p_slot(edit_pointer)] <= wr_char;
    if (cmd_i.mem_rd) rdata <= line_store[raddr];
  end

  // Pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer   <= '0;
      commit_pointer <= '0;
      edit_pointer   <= '0;
    end else begin
      read_pointer   <= read_pointer_next;
      commit_pointer <= commit_pointer_next;
      edit_pointer   <= edit_pointer_next;
    end
  end

  // Item capture and result accumulation.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      it_cmd   <= cmd;
      it_char  <= rx_char;
      it_first <= read_first;
    end
    res_echo_valid <= res_echo_valid_next;
    res_echo_char  <= res_echo_char_next;
    res_erase      <= res_erase_next;
    res_dump       <= res_dump_next;
    res_line_ready <= res_line_ready_next;
    res_read_valid <= res_read_valid_next;
    res_read_char  <= res_read_char_next;
    res_eof        <= res_eof_next;
    res_empty      <= res_empty_next;
    res_line_end   <= res_line_end_next;
  end

  // Output register, held until the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      echo_valid    <= res_echo_valid;
      echo_char     <= res_echo_char;
      erase_count   <= res_erase;
      dump_request  <= res_dump;
      line_ready    <= res_line_ready;
      read_valid    <= res_read_valid;
      read_char     <= res_read_char;
      read_eof      <= res_eof;
      read_empty    <= res_empty;
      read_line_end <= res_line_end;
    end
  end

  // The ring never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= DEPTH_P)
    else $error("ring fill exceeds depth");

  // The commit point lies between the read and edit points.
  a_commit_order: assert property (@(posedge clk) disable iff (rst)
    p_dist(commit_pointer, read_pointer) <= fill)
    else $error("commit point outside read..edit span");

  // Kill-line never erases past the commit point.
  a_kill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_i.kill_step |-> (edit_pointer != commit_pointer))
    else $error("erase past commit point");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd_i.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten");

endmodule

[sv/console_line_editing_buffer.sv]
// A received byte is decoded and carried out, then its result is loaded into the output register;
// a read first fetches its byte from the line store, and a Ctrl-U erases back over the line.
// Throughput: one item at a time; the next item is accepted the cycle after the result is
// loaded, and a kill-line erase walks the single read port of the line store back one byte per cycle.
// Reset (rst, synchronous) clears the pointers, the controller and the output valid.
module console_line_editing_buffer #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd,
  input  logic [7:0] rx_char,
  input  logic       read_first,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       echo_valid,
  output logic [7:0] echo_char,
  output logic [7:0] erase_count,
  output logic       dump_request,
  output logic       line_ready,
  output logic       read_valid,
  output logic [7:0] read_char,
  output logic       read_eof,
  output logic       read_empty,
  output logic       read_line_end
);

  clebuf_pkg::ctrl_cmd_t  ctrl_cmd;
  clebuf_pkg::dp_status_t dp_status;

  clebuf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd_o    (ctrl_cmd)
  );

  clebuf_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd_i         (ctrl_cmd),
    .status        (dp_status),
    .cmd           (cmd),
    .rx_char       (rx_char),
    .read_first    (read_first),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .echo_valid    (echo_valid),
    .echo_char     (echo_char),
    .erase_count   (erase_count),
    .dump_request  (dump_request),
    .line_ready    (line_ready),
    .read_valid    (read_valid),
    .read_char     (read_char),
    .read_eof      (read_eof),
    .read_empty    (read_empty),
    .read_line_end (read_line_end)
  );

endmodule
